### sv/msa_pkg.sv
// shared types and constants for the max score assignment block
package msa_pkg;

  localparam int ROW_BITS = 8;
  localparam int SCORE_W  = 7;
  localparam int PCNT_W   = 4;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_LOAD_STUDENT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_MENTOR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START        = 2'd2;

  localparam logic REG_PAIR_COUNT     = 1'b0;
  localparam logic REG_QUESTION_COUNT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [2:0]          row_index;
    logic [ROW_BITS-1:0] answer_bits;
  } in_word_t;

  typedef struct packed {
    logic [SCORE_W-1:0] best_score;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } seq_state_t;

  // control from the sequencer to the score unit
  typedef struct packed {
    logic issue;
    logic zero_prev;
    logic clear;
  } su_ctl_t;

endpackage

### sv/msa_stream_if.sv
// valid/ready channel carrying one word of a given type
interface msa_stream_if #(
  parameter type word_t = logic
) ();
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/msa_score_unit.sv
// shared score, add and max unit for the subset search
module msa_score_unit
  import msa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  su_ctl_t             ctl,
  input  logic [ROW_BITS-1:0] student_row,
  input  logic [ROW_BITS-1:0] mentor_row,
  input  logic [ROW_BITS-1:0] qmask,
  input  logic [SCORE_W-1:0]  rd_data,
  output logic [SCORE_W-1:0]  best_nxt
);

  logic [PCNT_W-1:0]  score_c;
  logic [PCNT_W-1:0]  score_r;
  logic               vld_r;
  logic               zero_r;
  logic [SCORE_W-1:0] best_r;
  logic [SCORE_W-1:0] prev_val;
  logic [SCORE_W:0]   sum;
  logic [ROW_BITS-1:0] agree;

  // matching answers within the compared questions
  always_comb begin
    agree   = ~(student_row ^ mentor_row) & qmask;
    score_c = '0;
    for (int i = 0; i < ROW_BITS; i++) begin
      score_c = score_c + PCNT_W'(agree[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_c;
    zero_r  <= ctl.zero_prev;
    best_r  <= best_nxt;
  end

  always_comb begin
    prev_val = zero_r ? '0 : rd_data;
    sum      = {1'b0, prev_val} + (SCORE_W+1)'(score_r);
    if (ctl.clear) begin
      best_nxt = '0;
    end else if (vld_r && (sum > {1'b0, best_r})) begin
      best_nxt = sum[SCORE_W-1:0];
    end else begin
      best_nxt = best_r;
    end
  end

endmodule

### sv/msa_seq.sv
// subset sequencer with the best-by-subset table
module msa_seq
  import msa_pkg::*;
#(
  parameter int MAX_PAIRS     = 8,
  parameter int MAX_QUESTIONS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [3:0]                pair_cfg,
  input  logic [3:0]                question_cfg,
  input  logic                      out_free,
  input  logic [SCORE_W-1:0]        best_nxt,
  output su_ctl_t                   ctl,
  output logic [ROW_BITS-1:0]       qmask,
  output logic [SCORE_W-1:0]        rd_data,
  output logic [(MAX_PAIRS > 1 ? $clog2(MAX_PAIRS) : 1)-1:0] stu_idx,
  output logic [(MAX_PAIRS > 1 ? $clog2(MAX_PAIRS) : 1)-1:0] men_idx,
  output logic                      idle,
  output logic                      done,
  output logic [SCORE_W-1:0]        result
);

  localparam int PW    = MAX_PAIRS;
  localparam int JW    = MAX_PAIRS > 1 ? $clog2(MAX_PAIRS) : 1;
  localparam int NW    = $clog2(MAX_PAIRS + 1);
  localparam int Q_LIM = MAX_QUESTIONS < ROW_BITS ? MAX_QUESTIONS : ROW_BITS;
  localparam int DEPTH = 1 << MAX_PAIRS;

  seq_state_t          state_r, state_nxt;
  logic [PW-1:0]       set_r, set_nxt;
  logic [JW-1:0]       j_r, j_nxt;
  logic [NW-1:0]       n_r, n_nxt;
  logic [PW-1:0]       full_r, full_nxt;
  logic [ROW_BITS-1:0] qmask_r, qmask_nxt;
  logic [SCORE_W-1:0]  res_r, res_nxt;
  logic [SCORE_W-1:0]  rd_r;
  logic [PW-1:0]       bit_sel;
  logic [PW-1:0]       rd_addr;
  logic [NW-1:0]       ones_cnt;
  logic                last_j;
  logic                tbl_we;

  logic [SCORE_W-1:0] table_mem [DEPTH];

  always_comb begin
    bit_sel = PW'(1) << j_r;
    rd_addr = set_r ^ bit_sel;
    last_j  = (NW'(j_r) + NW'(1)) == n_r;
    ones_cnt = '0;
    for (int i = 0; i < PW; i++) begin
      ones_cnt = ones_cnt + NW'(set_r[i]);
    end
  end

  assign stu_idx = JW'(ones_cnt - NW'(1));
  assign men_idx = j_r;
  assign qmask   = qmask_r;
  assign rd_data = rd_r;
  assign result  = res_r;
  assign idle    = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    set_r   <= set_nxt;
    j_r     <= j_nxt;
    n_r     <= n_nxt;
    full_r  <= full_nxt;
    qmask_r <= qmask_nxt;
    res_r   <= res_nxt;
  end

  // table port: one read and one write a cycle, read data registered
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_mem[set_r] <= best_nxt;
    end
    if (ctl.issue) begin
      rd_r <= table_mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    set_nxt   = set_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    full_nxt  = full_r;
    qmask_nxt = qmask_r;
    res_nxt   = res_r;
    tbl_we    = 1'b0;
    done      = 1'b0;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (pair_cfg == '0) begin
            n_nxt = NW'(1);
          end else if (32'(pair_cfg) > MAX_PAIRS) begin
            n_nxt = NW'(MAX_PAIRS);
          end else begin
            n_nxt = NW'(pair_cfg);
          end
          for (int i = 0; i < PW; i++) begin
            full_nxt[i] = i < 32'(n_nxt);
          end
          for (int i = 0; i < ROW_BITS; i++) begin
            if (question_cfg == '0) begin
              qmask_nxt[i] = (i == 0);
            end else begin
              qmask_nxt[i] = (i < 32'(question_cfg)) && (i < Q_LIM);
            end
          end
          set_nxt   = PW'(1);
          j_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ctl.clear     = (j_r == '0);
        ctl.issue     = |(set_r & bit_sel);
        ctl.zero_prev = (rd_addr == '0);
        if (last_j) begin
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      ST_DRAIN: begin
        tbl_we = 1'b1;
        if (set_r == full_r) begin
          res_nxt   = best_nxt;
          state_nxt = ST_DONE;
        end else begin
          set_nxt   = set_r + PW'(1);
          j_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // a drain only follows the last mentor of a subset
  a_drain_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> $past(state_r) == ST_ISSUE && $past(last_j))
    else $error("drain without finished subset");

  // the table is only read below the subset being built
  a_read_below: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.issue |-> rd_addr < set_r)
    else $error("table read at or above current subset");

  // the walked subset stays inside the used mentors
  a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> set_r != '0 && (set_r & ~full_r) == '0)
    else $error("subset outside used mentors");

  // a result leaves only once the search reached the full set
  a_done_after_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && $past(state_r) != ST_DONE |-> $past(set_r) == $past(full_r))
    else $error("result before full subset");

endmodule

### sv/max_score_assignment_top.sv
// top level of the max score assignment block
//
//  channel  | dir | signals                         | word
//  in_ch    | in  | valid, ready, data (in_word_t)  | cmd, row_index, answer_bits
//  out_ch   | out | valid, ready, data (out_word_t) | best_score
//  cfg      | in  | psel penable pwrite paddr ...   | pair_count @0, question_count @4
//
// load words are accepted whenever the search is idle; a start word walks every
// nonempty subset of the n pairs in use, one mentor candidate per cycle while issuing,
// through the shared add and max unit and the single table read port, then writes
// the subset's table entry in a drain state; reset (rst_n low, synchronous) clears
// control state and sets both count registers to 8; rows and table hold garbage
// until written, and a search writes every table entry it uses before it reads it,
// entry 0 reading as zero; a result waiting in the output register does not block
// loads; a finished search holds until the output register is free
module max_score_assignment_top
  import msa_pkg::*;
#(
  parameter int MAX_PAIRS     = 8,
  parameter int MAX_QUESTIONS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  msa_stream_if.sink   in_ch,
  msa_stream_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int JW = MAX_PAIRS > 1 ? $clog2(MAX_PAIRS) : 1;

  // configuration registers, raw as written
  logic [3:0] pair_cfg_r;
  logic [3:0] question_cfg_r;

  // answer rows
  logic [ROW_BITS-1:0] student_rows_r [MAX_PAIRS];
  logic [ROW_BITS-1:0] mentor_rows_r  [MAX_PAIRS];

  // output register
  logic               out_valid_r;
  logic [SCORE_W-1:0] out_score_r;

  logic                in_fire;
  logic                row_ok;
  logic                start;
  logic                out_free;
  logic                seq_idle;
  logic                seq_done;
  logic [SCORE_W-1:0]  seq_result;
  logic [SCORE_W-1:0]  best_nxt;
  logic [SCORE_W-1:0]  rd_data;
  logic [ROW_BITS-1:0] qmask;
  logic [JW-1:0]       stu_idx;
  logic [JW-1:0]       men_idx;
  su_ctl_t             ctl;
  logic                cfg_wr;

  // apb register port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_QUESTION_COUNT) ? {28'd0, question_cfg_r}
                                                   : {28'd0, pair_cfg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cfg_r     <= 4'd8;
      question_cfg_r <= 4'd8;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_QUESTION_COUNT) begin
        question_cfg_r <= pwdata[3:0];
      end else begin
        pair_cfg_r <= pwdata[3:0];
      end
    end
  end

  // input side: loads go straight to the row registers
  assign in_ch.ready = seq_idle;
  assign in_fire     = in_ch.valid && seq_idle;
  assign row_ok      = 32'(in_ch.data.row_index) < MAX_PAIRS;
  assign start       = in_fire && (in_ch.data.cmd == CMD_START);

  always_ff @(posedge clk) begin
    if (in_fire && row_ok) begin
      if (in_ch.data.cmd == CMD_LOAD_STUDENT) begin
        student_rows_r[JW'(in_ch.data.row_index)] <= in_ch.data.answer_bits;
      end
      if (in_ch.data.cmd == CMD_LOAD_MENTOR) begin
        mentor_rows_r[JW'(in_ch.data.row_index)] <= in_ch.data.answer_bits;
      end
    end
  end

  // subset sequencer and table
  msa_seq #(
    .MAX_PAIRS     (MAX_PAIRS),
    .MAX_QUESTIONS (MAX_QUESTIONS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .pair_cfg     (pair_cfg_r),
    .question_cfg (question_cfg_r),
    .out_free     (out_free),
    .best_nxt     (best_nxt),
    .ctl          (ctl),
    .qmask        (qmask),
    .rd_data      (rd_data),
    .stu_idx      (stu_idx),
    .men_idx      (men_idx),
    .idle         (seq_idle),
    .done         (seq_done),
    .result       (seq_result)
  );

  // shared score, add and max unit
  msa_score_unit u_score (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .student_row (student_rows_r[stu_idx]),
    .mentor_row  (mentor_rows_r[men_idx]),
    .qmask       (qmask),
    .rd_data     (rd_data),
    .best_nxt    (best_nxt)
  );

  // output register, freed in the cycle it is taken
  assign out_free                = !out_valid_r || out_ch.ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.data.best_score  = out_score_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_score_r <= seq_result;
    end
  end

  // a finished search always lands in the output register
  a_done_lands: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |=> out_valid_r && out_score_r == $past(seq_result))
    else $error("result lost on the way out");

  // a start word is only taken with the sequencer idle, and it leaves idle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !seq_idle)
    else $error("search did not begin");

  // a pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !seq_done)
    else $error("result overwritten");

endmodule
